// ----- rtl/core/ksfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ksfr_pkg;

	// default geometry of the store
	localparam int SLOT_COUNT_DEF = 16;
	localparam int SLOT_WORDS_DEF = 8;

	// fixed field widths
	localparam int CMD_W   = 2;
	localparam int KEY_W   = 32;
	localparam int EIDX_W  = 3;
	localparam int DATA_W  = 32;
	localparam int STAT_W  = 2;
	localparam int SIU_W   = 5;

	// slots_in_use after reset
	localparam logic [SIU_W-1:0] SIU_RESET = 5'd16;

	// request commands
	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK           = 2'd0,
		STAT_NOT_FOUND    = 2'd1,
		STAT_NEW_NOT_ZERO = 2'd2
	} stat_code_t;

	// ram word offset select within a slot
	typedef enum logic [1:0] {
		OFF_EIDX,
		OFF_CNT,
		OFF_CNT_NEXT
	} off_sel_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_EXEC,
		ST_FILL,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_RESP
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic       capture;
		logic       lookup;
		logic       claim;
		logic       clear_all;
		logic       cnt_clr;
		logic       cnt_inc;
		logic       ram_we;
		logic       ram_re;
		off_sel_t   off_sel;
		logic       out_load;
		logic       out_data;
		stat_code_t resp_status;
	} ksfr_ctrl_t;

	// status from datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic hit;
		logic eidx_ok;
		logic eidx_zero;
		logic cnt_last;
		logic out_free;
	} ksfr_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/ksfr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ksfr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/ksfr_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ksfr_dpath #(
	parameter int SLOT_COUNT = ksfr_pkg::SLOT_COUNT_DEF,
	parameter int SLOT_WORDS = ksfr_pkg::SLOT_WORDS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [ksfr_pkg::SIU_W-1:0]   cfg_wdata,
	input  wire logic [ksfr_pkg::CMD_W-1:0]   cmd,
	input  wire logic [ksfr_pkg::KEY_W-1:0]   key,
	input  wire logic [ksfr_pkg::EIDX_W-1:0]  element_index,
	input  wire logic [ksfr_pkg::DATA_W-1:0]  value,
	input  wire logic                         out_ready,
	output logic                              out_valid,
	output logic      [ksfr_pkg::STAT_W-1:0]  status,
	output logic      [ksfr_pkg::DATA_W-1:0]  value_res,
	output logic      [ksfr_pkg::EIDX_W-1:0]  element_index_res,
	output logic                              last,
	input  wire ksfr_pkg::ksfr_ctrl_t         ctrl,
	output ksfr_pkg::ksfr_stat_t              stat
);

	localparam int DEPTH = SLOT_COUNT * SLOT_WORDS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW    = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
	localparam int NW    = $clog2(SLOT_COUNT + 1);

	// request registers
	logic [ksfr_pkg::CMD_W-1:0]  cmd_q;
	logic [ksfr_pkg::KEY_W-1:0]  key_q;
	logic [ksfr_pkg::EIDX_W-1:0] eidx_q;
	logic [ksfr_pkg::DATA_W-1:0] val_q;

	// slot state
	logic [ksfr_pkg::KEY_W-1:0]  tags_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]       valid_q;
	logic [SW-1:0]               next_victim_q;
	logic [ksfr_pkg::SIU_W-1:0]  siu_q;

	// lookup result and word counter
	logic                        hit_q;
	logic [SW-1:0]               slot_q;
	logic [CW-1:0]               cnt_q;

	// output register
	logic                        out_valid_q;
	logic [ksfr_pkg::STAT_W-1:0] status_q;
	logic [ksfr_pkg::DATA_W-1:0] value_res_q;
	logic [ksfr_pkg::EIDX_W-1:0] eidx_res_q;
	logic                        last_q;

	logic                        hit_c;
	logic [SW-1:0]               hit_slot_c;
	logic [NW-1:0]               n_eff;
	logic [SW-1:0]               victim;
	logic [SW-1:0]               victim_next;
	logic [AW-1:0]               base_addr;
	logic [AW-1:0]               off_addr;
	logic [AW-1:0]               ram_addr;
	logic [ksfr_pkg::DATA_W-1:0] ram_wdata;
	logic [ksfr_pkg::DATA_W-1:0] ram_rdata;
	logic [31:0]                 cnt_ext;
	logic                        cnt_last;
	logic                        out_free;

	// request capture
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q  <= cmd;
			key_q  <= key;
			eidx_q <= element_index;
			val_q  <= value;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			siu_q <= ksfr_pkg::SIU_RESET;
		end else if (cfg_we) begin
			siu_q <= cfg_wdata;
		end
	end

	// parallel tag compare, lowest matching slot wins
	always_comb begin
		hit_c      = 1'b0;
		hit_slot_c = '0;
		for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
			if (valid_q[s] && (tags_q[s] == key_q)) begin
				hit_c      = 1'b1;
				hit_slot_c = SW'(s);
			end
		end
	end

	// effective slot count and replacement victim
	always_comb begin
		if (siu_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(siu_q) > SLOT_COUNT) begin
			n_eff = NW'(SLOT_COUNT);
		end else begin
			n_eff = NW'(siu_q);
		end
		if (32'(next_victim_q) >= 32'(n_eff)) begin
			victim = '0;
		end else begin
			victim = next_victim_q;
		end
		if ((32'(victim) + 32'd1) >= 32'(n_eff)) begin
			victim_next = '0;
		end else begin
			victim_next = victim + SW'(1);
		end
	end

	// tag store, no reset
	always_ff @(posedge clk) begin
		if (ctrl.claim) begin
			tags_q[victim] <= key_q;
		end
	end

	// valid bits and replacement pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			next_victim_q <= '0;
		end else if (ctrl.clear_all) begin
			valid_q       <= '0;
			next_victim_q <= '0;
		end else if (ctrl.claim) begin
			valid_q[victim] <= 1'b1;
			next_victim_q   <= victim_next;
		end
	end

	// lookup result, replaced by the victim on a claim
	always_ff @(posedge clk) begin
		if (ctrl.lookup) begin
			hit_q  <= hit_c;
			slot_q <= hit_slot_c;
		end else if (ctrl.claim) begin
			slot_q <= victim;
		end
	end

	// word counter within a slot
	always_ff @(posedge clk) begin
		if (ctrl.cnt_clr) begin
			cnt_q <= '0;
		end else if (ctrl.cnt_inc) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	assign cnt_ext  = 32'(cnt_q);
	assign cnt_last = (cnt_ext == 32'(SLOT_WORDS - 1));

	// ram address: slot base plus word offset
	always_comb begin
		base_addr = AW'(slot_q) * AW'(SLOT_WORDS);
		case (ctrl.off_sel)
			ksfr_pkg::OFF_EIDX:     off_addr = AW'(eidx_q);
			ksfr_pkg::OFF_CNT:      off_addr = AW'(cnt_q);
			ksfr_pkg::OFF_CNT_NEXT: off_addr = AW'(cnt_q) + AW'(1);
			default:                off_addr = AW'(cnt_q);
		endcase
		ram_addr = base_addr + off_addr;
	end

	// fill writes the value at word zero and zeros elsewhere
	assign ram_wdata = ((ctrl.off_sel == ksfr_pkg::OFF_CNT) && (cnt_q != '0)) ? '0 : val_q;

	ksfr_ram #(
		.WIDTH(ksfr_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_data_ram (
		.clk  (clk),
		.we   (ctrl.ram_we),
		.waddr(ram_addr),
		.wdata(ram_wdata),
		.re   (ctrl.ram_re),
		.raddr(ram_addr),
		.rdata(ram_rdata)
	);

	// output register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			if (ctrl.out_data) begin
				status_q    <= ksfr_pkg::STAT_OK;
				value_res_q <= ram_rdata;
				eidx_res_q  <= cnt_ext[ksfr_pkg::EIDX_W-1:0];
				last_q      <= cnt_last;
			end else begin
				status_q    <= ctrl.resp_status;
				value_res_q <= '0;
				eidx_res_q  <= '0;
				last_q      <= 1'b1;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign value_res         = value_res_q;
	assign element_index_res = eidx_res_q;
	assign last              = last_q;

	// status to controller
	assign stat.cmd       = ksfr_pkg::cmd_t'(cmd_q);
	assign stat.hit       = hit_q;
	assign stat.eidx_ok   = (32'(eidx_q) < SLOT_WORDS);
	assign stat.eidx_zero = (eidx_q == '0);
	assign stat.cnt_last  = cnt_last;
	assign stat.out_free  = out_free;

	// output register is only loaded when free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> out_free)
		else $error("result loaded over a pending result");

	// counter never steps past the last word
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.cnt_inc |-> !cnt_last)
		else $error("word counter stepped past slot end");

	// a claim leaves its slot valid with the new tag
	a_claim: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.claim |=> (valid_q[slot_q] && (tags_q[slot_q] == key_q)))
		else $error("claimed slot not valid with new tag");

	// clear empties the store
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clear_all |=> ((valid_q == '0) && (next_victim_q == '0)))
		else $error("clear left valid slots");

	// replacement pointer stays within the store
	a_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(next_victim_q) < SLOT_COUNT))
		else $error("replacement pointer out of range");

endmodule

`default_nettype wire

// ----- rtl/core/ksfr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ksfr_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire ksfr_pkg::ksfr_stat_t stat,
	output ksfr_pkg::ksfr_ctrl_t      ctrl
);

	ksfr_pkg::state_t     state_q;
	ksfr_pkg::state_t     state_d;
	ksfr_pkg::stat_code_t resp_q;
	ksfr_pkg::stat_code_t resp_d;

	// state and pending response status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ksfr_pkg::ST_IDLE;
			resp_q  <= ksfr_pkg::STAT_OK;
		end else begin
			state_q <= state_d;
			resp_q  <= resp_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d          = state_q;
		resp_d           = resp_q;
		in_ready         = 1'b0;
		ctrl             = '0;
		ctrl.off_sel     = ksfr_pkg::OFF_EIDX;
		ctrl.resp_status = resp_q;
		unique case (state_q)
			ksfr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.capture = 1'b1;
					state_d      = ksfr_pkg::ST_LOOKUP;
				end
			end
			ksfr_pkg::ST_LOOKUP: begin
				ctrl.lookup = 1'b1;
				state_d     = ksfr_pkg::ST_EXEC;
			end
			ksfr_pkg::ST_EXEC: begin
				unique case (stat.cmd)
					ksfr_pkg::CMD_WRITE: begin
						if (stat.hit) begin
							ctrl.ram_we = stat.eidx_ok;
							resp_d      = ksfr_pkg::STAT_OK;
							state_d     = ksfr_pkg::ST_RESP;
						end else if (!stat.eidx_zero) begin
							resp_d  = ksfr_pkg::STAT_NEW_NOT_ZERO;
							state_d = ksfr_pkg::ST_RESP;
						end else begin
							ctrl.claim   = 1'b1;
							ctrl.cnt_clr = 1'b1;
							state_d      = ksfr_pkg::ST_FILL;
						end
					end
					ksfr_pkg::CMD_READ: begin
						if (stat.hit) begin
							ctrl.cnt_clr = 1'b1;
							state_d      = ksfr_pkg::ST_RD_ADDR;
						end else begin
							resp_d  = ksfr_pkg::STAT_NOT_FOUND;
							state_d = ksfr_pkg::ST_RESP;
						end
					end
					ksfr_pkg::CMD_CLEAR: begin
						ctrl.clear_all = 1'b1;
						resp_d         = ksfr_pkg::STAT_OK;
						state_d        = ksfr_pkg::ST_RESP;
					end
					default: begin
						resp_d  = ksfr_pkg::STAT_OK;
						state_d = ksfr_pkg::ST_RESP;
					end
				endcase
			end
			ksfr_pkg::ST_FILL: begin
				// zero-fill the claimed slot, new value at word zero
				ctrl.ram_we  = 1'b1;
				ctrl.off_sel = ksfr_pkg::OFF_CNT;
				if (stat.cnt_last) begin
					resp_d  = ksfr_pkg::STAT_OK;
					state_d = ksfr_pkg::ST_RESP;
				end else begin
					ctrl.cnt_inc = 1'b1;
				end
			end
			ksfr_pkg::ST_RD_ADDR: begin
				ctrl.ram_re  = 1'b1;
				ctrl.off_sel = ksfr_pkg::OFF_CNT;
				state_d      = ksfr_pkg::ST_RD_DATA;
			end
			ksfr_pkg::ST_RD_DATA: begin
				// hand out one word and fetch the next in the same cycle
				if (stat.out_free) begin
					ctrl.out_load = 1'b1;
					ctrl.out_data = 1'b1;
					if (stat.cnt_last) begin
						state_d = ksfr_pkg::ST_IDLE;
					end else begin
						ctrl.cnt_inc = 1'b1;
						ctrl.ram_re  = 1'b1;
						ctrl.off_sel = ksfr_pkg::OFF_CNT_NEXT;
					end
				end
			end
			ksfr_pkg::ST_RESP: begin
				if (stat.out_free) begin
					ctrl.out_load = 1'b1;
					state_d       = ksfr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ksfr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/keyed_slot_store_fifo_replace_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// request   in         in_valid / in_ready  cmd, key, element_index, value
// result    out        out_valid/out_ready  status, value_res, element_index_res, last
// config    in         cfg_we               cfg_wdata (slots_in_use)
//
// one request at a time: accept, tag lookup, execute, then result; a write, clear,
// miss or error goes from execute straight to its result, a new-key write first
// zero-fills its slot (one ram word per cycle) and a read hit streams its words
// one per cycle from the data ram while the result side is ready.
// reset clears valid bits, replacement pointer and control; no clearing pass.
// a stalled result holds the word stream; the next request waits for the last.

module keyed_slot_store_fifo_replace_unit #(
	parameter int SLOT_COUNT = ksfr_pkg::SLOT_COUNT_DEF,
	parameter int SLOT_WORDS = ksfr_pkg::SLOT_WORDS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [ksfr_pkg::SIU_W-1:0]   cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [ksfr_pkg::CMD_W-1:0]   cmd,
	input  wire logic [ksfr_pkg::KEY_W-1:0]   key,
	input  wire logic [ksfr_pkg::EIDX_W-1:0]  element_index,
	input  wire logic [ksfr_pkg::DATA_W-1:0]  value,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [ksfr_pkg::STAT_W-1:0]  status,
	output logic      [ksfr_pkg::DATA_W-1:0]  value_res,
	output logic      [ksfr_pkg::EIDX_W-1:0]  element_index_res,
	output logic                              last
);

	ksfr_pkg::ksfr_ctrl_t ctrl;
	ksfr_pkg::ksfr_stat_t stat;

	// sequencer
	ksfr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.ctrl    (ctrl)
	);

	// tags, data ram and result register
	ksfr_dpath #(
		.SLOT_COUNT(SLOT_COUNT),
		.SLOT_WORDS(SLOT_WORDS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.cmd              (cmd),
		.key              (key),
		.element_index    (element_index),
		.value            (value),
		.out_ready        (out_ready),
		.out_valid        (out_valid),
		.status           (status),
		.value_res        (value_res),
		.element_index_res(element_index_res),
		.last             (last),
		.ctrl             (ctrl),
		.stat             (stat)
	);

endmodule

`default_nettype wire

// ----- dv/tb_keyed_slot_store_fifo_replace_unit.sv -----
`timescale 1ns / 1ps

module tb_keyed_slot_store_fifo_replace_unit;

	localparam int NSLOT = ksfr_pkg::SLOT_COUNT_DEF;
	localparam int SSIZE = ksfr_pkg::SLOT_WORDS_DEF;
	localparam int SETTLE = SSIZE + 8;
	localparam int PHASE_ITEMS = 17;

	// field widths
	localparam int KW  = ksfr_pkg::KEY_W;
	localparam int DW  = ksfr_pkg::DATA_W;
	localparam int EW  = ksfr_pkg::EIDX_W;
	localparam int STW = ksfr_pkg::STAT_W;
	localparam int CMW = ksfr_pkg::CMD_W;
	localparam int UW  = ksfr_pkg::SIU_W;

	// short names for request and status codes
	localparam ksfr_pkg::cmd_t       C_WR   = ksfr_pkg::CMD_WRITE;
	localparam ksfr_pkg::cmd_t       C_RD   = ksfr_pkg::CMD_READ;
	localparam ksfr_pkg::cmd_t       C_CLR  = ksfr_pkg::CMD_CLEAR;
	localparam ksfr_pkg::cmd_t       C_NOP  = ksfr_pkg::CMD_NONE;
	localparam ksfr_pkg::stat_code_t S_OK   = ksfr_pkg::STAT_OK;
	localparam ksfr_pkg::stat_code_t S_MISS = ksfr_pkg::STAT_NOT_FOUND;
	localparam ksfr_pkg::stat_code_t S_NEW  = ksfr_pkg::STAT_NEW_NOT_ZERO;

	// one word of a response
	typedef struct {
		logic [STW-1:0] status;
		logic [DW-1:0]  val;
		logic [EW-1:0]  idx;
		logic           last;
	} word_res_t;

	// directed row: either a slots_in_use write or a request
	typedef struct {
		logic                 is_cfg;
		logic [UW-1:0]        siu;
		ksfr_pkg::cmd_t       op;
		logic [KW-1:0]        k;
		logic [EW-1:0]        ei;
		logic [DW-1:0]        v;
		logic                 typed;
		ksfr_pkg::stat_code_t st;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [UW-1:0]       cfg_wdata;
	logic                in_valid;
	logic                in_ready;
	logic [CMW-1:0]      cmd;
	logic [KW-1:0]       key;
	logic [EW-1:0]       element_index;
	logic [DW-1:0]       value;
	logic                out_valid;
	logic                out_ready;
	logic [STW-1:0]      status;
	logic [DW-1:0]       value_res;
	logic [EW-1:0]       element_index_res;
	logic                last;

	// mirror of the store contents
	logic [KW-1:0]       mirror_tag [NSLOT];
	logic                mirror_valid [NSLOT];
	logic [DW-1:0]       mirror_data [NSLOT*SSIZE];
	int                  mirror_victim;
	logic [UW-1:0]       mirror_siu;

	word_res_t           fresh_words[$];
	word_res_t           pending_words[$];

	// row-level typed expectation travels with the request
	logic                 row_typed;
	ksfr_pkg::stat_code_t row_status;

	logic                quiet;
	int                  fault_count;
	int                  req_count;
	int                  word_count;
	int                  read_hits;
	int                  claim_count;
	int                  evict_count;
	int                  cfg_count;

	logic [KW-1:0]       key_pool [24];
	dir_row_t            dir_tab [30];

	keyed_slot_store_fifo_replace_unit dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.cmd               (cmd),
		.key               (key),
		.element_index     (element_index),
		.value             (value),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.value_res         (value_res),
		.element_index_res (element_index_res),
		.last              (last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic word_res_t make_word(ksfr_pkg::stat_code_t s, logic [DW-1:0] v,
			logic [EW-1:0] i, logic l);
		word_res_t w;
		w.status = s;
		w.val = v;
		w.idx = i;
		w.last = l;
		return w;
	endfunction

	// lowest valid slot holding the key, -1 on miss
	function automatic int slot_of(logic [KW-1:0] k);
		int hit;
		hit = -1;
		for (int s = NSLOT - 1; s >= 0; s--)
			if (mirror_valid[s] && mirror_tag[s] == k)
				hit = s;
		return hit;
	endfunction

	// apply one request to the mirror and collect its response words
	task automatic mirror_request(input ksfr_pkg::cmd_t c, input logic [KW-1:0] k,
			input logic [EW-1:0] e, input logic [DW-1:0] v);
		int hit;
		int n;
		int vic;
		fresh_words.delete();
		hit = slot_of(k);
		case (c)
			C_WR: begin
				if (hit >= 0) begin
					if (e < SSIZE)
						mirror_data[hit*SSIZE + e] = v;
					fresh_words.push_back(make_word(S_OK, '0, '0, 1'b1));
				end else if (e != 0) begin
					fresh_words.push_back(make_word(S_NEW, '0, '0, 1'b1));
				end else begin
					// claim the oldest slot within the active range
					n = (mirror_siu == 0) ? 1 : int'(mirror_siu);
					if (n > NSLOT)
						n = NSLOT;
					vic = mirror_victim;
					if (vic >= n)
						vic = 0;
					if (mirror_valid[vic])
						evict_count++;
					mirror_tag[vic] = k;
					mirror_valid[vic] = 1'b1;
					for (int i = 0; i < SSIZE; i++)
						mirror_data[vic*SSIZE + i] = '0;
					mirror_data[vic*SSIZE] = v;
					vic++;
					if (vic >= n)
						vic = 0;
					mirror_victim = vic;
					claim_count++;
					fresh_words.push_back(make_word(S_OK, '0, '0, 1'b1));
				end
			end
			C_RD: begin
				if (hit < 0) begin
					fresh_words.push_back(make_word(S_MISS, '0, '0, 1'b1));
				end else begin
					read_hits++;
					for (int i = 0; i < SSIZE; i++)
						fresh_words.push_back(make_word(S_OK, mirror_data[hit*SSIZE + i],
							EW'(i), i == SSIZE - 1));
				end
			end
			C_CLR: begin
				for (int s = 0; s < NSLOT; s++)
					mirror_valid[s] = 1'b0;
				mirror_victim = 0;
				fresh_words.push_back(make_word(S_OK, '0, '0, 1'b1));
			end
			default: begin
				fresh_words.push_back(make_word(S_OK, '0, '0, 1'b1));
			end
		endcase
	endtask

	// compare finished words, then record newly taken requests
	always @(posedge clk) begin : result_check
		word_res_t got;
		word_res_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = make_word(S_OK, value_res, element_index_res, last);
				got.status = status;
				word_count++;
				if (pending_words.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("unexpected word: st=%0d val=%h idx=%0d last=%0b",
							got.status, got.val, got.idx, got.last);
				end else begin
					want = pending_words.pop_front();
					if (got.status !== want.status || got.val !== want.val ||
							got.idx !== want.idx || got.last !== want.last) begin
						fault_count++;
						if (fault_count <= 10)
							$display({"mismatch: exp st=%0d val=%h idx=%0d last=%0b,",
								" got st=%0d val=%h idx=%0d last=%0b"},
								want.status, want.val, want.idx, want.last,
								got.status, got.val, got.idx, got.last);
					end
				end
			end
			if (in_valid && in_ready) begin
				req_count++;
				mirror_request(ksfr_pkg::cmd_t'(cmd), key, element_index, value);
				if (row_typed) begin
					pending_words.push_back(make_word(row_status, '0, '0, 1'b1));
				end else begin
					foreach (fresh_words[i])
						pending_words.push_back(fresh_words[i]);
				end
			end
		end
	end

	// result side backpressure
	initial begin : result_ready
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// present one request, return at the negedge after it is taken
	task automatic put_req(input ksfr_pkg::cmd_t c, input logic [KW-1:0] k,
			input logic [EW-1:0] e, input logic [DW-1:0] v,
			input logic t, input ksfr_pkg::stat_code_t s);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd <= c;
		key <= k;
		element_index <= e;
		value <= v;
		row_typed <= t;
		row_status <= s;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// hold off until every response word is back
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_words.size() != 0)
			@(negedge clk);
	endtask

	// write slots_in_use while the block is idle
	task automatic set_slots(input logic [UW-1:0] n);
		drain();
		repeat (SETTLE) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= n;
		@(negedge clk);
		cfg_we <= 1'b0;
		mirror_siu = n;
		cfg_count++;
	endtask

	// random request, mostly on a small key set so hits and evictions occur
	task automatic put_random();
		int r;
		ksfr_pkg::cmd_t c;
		logic [KW-1:0] k;
		logic [EW-1:0] e;
		r = $urandom_range(0, 99);
		if (r < 58)
			c = C_WR;
		else if (r < 90)
			c = C_RD;
		else if (r < 94)
			c = C_CLR;
		else
			c = C_NOP;
		k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 23)];
		e = ($urandom_range(0, 9) < 4) ? '0 : EW'($urandom_range(0, 7));
		put_req(c, k, e, $urandom, 1'b0, S_OK);
	endtask

	initial begin
		logic [UW-1:0] phase_siu [5];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		cmd = '0;
		key = '0;
		element_index = '0;
		value = '0;
		row_typed = 1'b0;
		row_status = S_OK;
		quiet = 1'b0;
		fault_count = 0;
		req_count = 0;
		word_count = 0;
		read_hits = 0;
		claim_count = 0;
		evict_count = 0;
		cfg_count = 0;
		for (int s = 0; s < NSLOT; s++)
			mirror_valid[s] = 1'b0;
		mirror_victim = 0;
		mirror_siu = ksfr_pkg::SIU_RESET;

		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < 24; i++)
			key_pool[i] = $urandom;

		// typed column: 1 = expected response written in the row
		dir_tab = '{
			'{1'b0, 5'd0,  C_RD,  32'h0000_0000, 3'd0, 32'h0000_0000, 1'b1, S_MISS},
			'{1'b0, 5'd0,  C_WR,  32'hffff_ffff, 3'd7, 32'h1234_5678, 1'b1, S_NEW},
			'{1'b0, 5'd0,  C_WR,  32'h0000_0000, 3'd0, 32'hffff_ffff, 1'b1, S_OK},
			'{1'b0, 5'd0,  C_WR,  32'h0000_0000, 3'd7, 32'h8000_0001, 1'b1, S_OK},
			'{1'b0, 5'd0,  C_WR,  32'h0000_0000, 3'd5, 32'haaaa_aaaa, 1'b0, S_OK},
			'{1'b0, 5'd0,  C_RD,  32'h0000_0000, 3'd0, 32'h0000_0000, 1'b0, S_OK},
			'{1'b0, 5'd0,  C_WR,  32'hffff_ffff, 3'd0, 32'h0000_0000, 1'b1, S_OK},
			'{1'b0, 5'd0,  C_WR,  32'hffff_ffff, 3'd6, 32'h5555_5555, 1'b0, S_OK},
			'{1'b0, 5'd0,  C_RD,  32'hffff_ffff, 3'd7, 32'hffff_ffff, 1'b0, S_OK},
			'{1'b0, 5'd0,  C_NOP, 32'hffff_ffff, 3'd7, 32'hffff_ffff, 1'b1, S_OK},
			'{1'b0, 5'd0,  C_CLR, 32'h0000_0000, 3'd0, 32'h0000_0000, 1'b1, S_OK},
			'{1'b0, 5'd0,  C_RD,  32'h0000_0000, 3'd0, 32'h0000_0000, 1'b1, S_MISS},
			'{1'b1, 5'd1,  C_NOP, 32'h0000_0000, 3'd0, 32'h0000_0000, 1'b0, S_OK},
			'{1'b0, 5'd0,  C_WR,  32'h0000_0011, 3'd0, 32'h3f80_0000, 1'b1, S_OK},
			'{1'b0, 5'd0,  C_WR,  32'h0000_0022, 3'd0, 32'hbf80_0000, 1'b1, S_OK},
			'{1'b0, 5'd0,  C_RD,  32'h0000_0011, 3'd0, 32'h0000_0000, 1'b1, S_MISS},
			'{1'b0, 5'd0,  C_RD,  32'h0000_0022, 3'd0, 32'h0000_0000, 1'b0, S_OK},
			'{1'b1, 5'd31, C_NOP, 32'h0000_0000, 3'd0, 32'h0000_0000, 1'b0, S_OK},
			'{1'b0, 5'd0,  C_WR,  32'h0000_0033, 3'd0, 32'h0000_0033, 1'b0, S_OK},
			'{1'b0, 5'd0,  C_WR,  32'h0000_0044, 3'd0, 32'h0000_0044, 1'b0, S_OK},
			'{1'b0, 5'd0,  C_WR,  32'h0000_0055, 3'd0, 32'h0000_0055, 1'b0, S_OK},
			'{1'b1, 5'd2,  C_NOP, 32'h0000_0000, 3'd0, 32'h0000_0000, 1'b0, S_OK},
			'{1'b0, 5'd0,  C_WR,  32'h0000_0066, 3'd0, 32'h0000_0066, 1'b0, S_OK},
			'{1'b0, 5'd0,  C_RD,  32'h0000_0033, 3'd0, 32'h0000_0000, 1'b1, S_MISS},
			'{1'b0, 5'd0,  C_RD,  32'h0000_0055, 3'd0, 32'h0000_0000, 1'b0, S_OK},
			'{1'b1, 5'd0,  C_NOP, 32'h0000_0000, 3'd0, 32'h0000_0000, 1'b0, S_OK},
			'{1'b0, 5'd0,  C_WR,  32'h0000_0077, 3'd0, 32'h0000_0077, 1'b0, S_OK},
			'{1'b0, 5'd0,  C_RD,  32'h0000_0066, 3'd0, 32'h0000_0000, 1'b1, S_MISS},
			'{1'b0, 5'd0,  C_RD,  32'h0000_0044, 3'd0, 32'h0000_0000, 1'b0, S_OK},
			'{1'b1, 5'd16, C_NOP, 32'h0000_0000, 3'd0, 32'h0000_0000, 1'b0, S_OK}
		};

		// reset
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg)
				set_slots(dir_tab[i].siu);
			else
				put_req(dir_tab[i].op, dir_tab[i].k, dir_tab[i].ei, dir_tab[i].v,
					dir_tab[i].typed, dir_tab[i].st);
		end

		// random phases under different slot counts
		phase_siu[0] = 5'd16;
		phase_siu[1] = 5'd3;
		phase_siu[2] = 5'd31;
		phase_siu[3] = 5'd1;
		phase_siu[4] = UW'($urandom_range(0, 31));
		for (int p = 0; p < 5; p++) begin
			set_slots(phase_siu[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// back-to-back stretch with no idling on either side
				quiet = (p == 1 && i < PHASE_ITEMS / 2);
				// sender holds off mid-phase until all responses are back
				if (p == 2 && i == PHASE_ITEMS / 2)
					drain();
				put_random();
			end
			quiet = 1'b0;
		end

		drain();
		repeat (SETTLE) @(negedge clk);
		if (pending_words.size() != 0) begin
			fault_count++;
			$display("%0d response words never arrived", pending_words.size());
		end

		$display("%0d requests, %0d words checked, %0d slot-count writes",
			req_count, word_count, cfg_count);
		$display("%0d read hits, %0d new-key claims, %0d evictions, %0d faults",
			read_hits, claim_count, evict_count, fault_count);
		if (fault_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/ksfr_pkg.sv
rtl/core/ksfr_ram.sv
rtl/core/ksfr_dpath.sv
rtl/core/ksfr_ctrl.sv
rtl/core/keyed_slot_store_fifo_replace_unit.sv
dv/tb_keyed_slot_store_fifo_replace_unit.sv
